// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
// Clocked on clk, with the asynchronous active-low reset arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/adrc_pkg.sv =====
// Shared widths, register codes, sideband types and the window function of the fhan pipeline.
// No dependencies; the other RTL files, apart from the checker and its macros, refer to it by scoped names.
package adrc_pkg;

	localparam int FRAC_BITS = 16;

	localparam int R_W    = 31;
	localparam int H_W    = 17;
	localparam int D_W    = 33;
	localparam int A0_W   = 33;
	localparam int Y_W    = 34;
	localparam int S_W    = 37;
	localparam int RAD_W  = 70;
	localparam int ROOT_W = 35;
	localparam int REM_W  = 37;
	localparam int A_W    = 37;
	localparam int MAG_W  = 36;
	localparam int N_W    = 67;
	localparam int Q_W    = 41;
	localparam int TOT_W  = 42;

	localparam logic [R_W-1:0] GAIN_R_RST = 31'd1966080000;
	localparam logic [H_W-1:0] STEP_H_RST = 17'd1311;
	localparam logic [Q_W-1:0] QUOT_CAP   = 41'h100_0000_0000;

	localparam logic [0:0] REG_GAIN_R = 1'b0;
	localparam logic [0:0] REG_STEP_H = 1'b1;

	// Twice the fsg window: inside, on the edge, outside.
	typedef enum logic [1:0] {
		WIN_OUT  = 2'd0,
		WIN_EDGE = 2'd1,
		WIN_IN   = 2'd2
	} win_t;

	typedef struct packed {
		logic signed [A0_W-1:0] a0;
		logic signed [Y_W-1:0]  y;
		logic [D_W-1:0]         d;
		win_t                   k;
	} root_side_t;

	typedef struct packed {
		win_t k;
		win_t g;
		logic aneg;
		logic azero;
	} quot_side_t;

	function automatic win_t fsg2(logic [MAG_W-1:0] m, logic [D_W-1:0] d);
		logic [MAG_W-1:0] dx;
		dx = MAG_W'(d);
		if (d == '0)
			return WIN_OUT;
		else if (m < dx)
			return WIN_IN;
		else if (m == dx)
			return WIN_EDGE;
		else
			return WIN_OUT;
	endfunction

endpackage

// ===== hw/rtl/adrc_front.sv =====
// Front stages: d = r*h*h, a0 = x2*h, y, the window of y and the radicand d*(d + 8|y|).
// Depends on adrc_pkg.
module adrc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic signed [31:0]                x1,
	input  logic signed [31:0]                x2,
	input  logic [adrc_pkg::R_W-1:0]          r,
	input  logic [adrc_pkg::H_W-1:0]          h,
	output logic                              out_valid,
	output logic [adrc_pkg::RAD_W-1:0]        rad,
	output adrc_pkg::root_side_t              side
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [47:0]               rh_s1;
	logic [48:0]               mp_s1;
	logic signed [31:0]        x1_s1, x1_s2;
	logic                      neg_s1;

	logic [48:0]               dp_s2;
	logic signed [adrc_pkg::A0_W-1:0] a0_s2, a0_s3;

	logic [adrc_pkg::D_W-1:0]  d_s3;
	logic signed [adrc_pkg::Y_W-1:0] y_s3;

	logic [adrc_pkg::S_W-1:0]  s_s4;
	adrc_pkg::root_side_t      side_s4, side_s5, side_s6;

	logic [51:0]               pl_s5;
	logic [50:0]               ph_s5;
	logic [adrc_pkg::RAD_W-1:0] rad_s6;

	logic [31:0]               x2_mag;
	logic [31:0]               a0_mag;
	logic signed [adrc_pkg::A0_W-1:0] a0_nx;
	logic [adrc_pkg::D_W-1:0]  y_mag;
	logic signed [adrc_pkg::Y_W-1:0]  y_neg;

	assign x2_mag = x2[31] ? (~x2 + 32'd1) : x2;
	assign a0_mag = mp_s1[adrc_pkg::FRAC_BITS +: 32];
	assign a0_nx  = neg_s1 ? -$signed({1'b0, a0_mag}) : $signed({1'b0, a0_mag});
	assign y_neg  = -y_s3;
	assign y_mag  = y_s3[adrc_pkg::Y_W-1] ? y_neg[adrc_pkg::D_W-1:0]
		: y_s3[adrc_pkg::D_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rh_s1  <= 48'(r) * 48'(h);
			mp_s1  <= 49'(x2_mag) * 49'(h);
			x1_s1  <= x1;
			neg_s1 <= x2[31];

			dp_s2  <= 49'(rh_s1[adrc_pkg::FRAC_BITS +: 32]) * 49'(h);
			a0_s2  <= a0_nx;
			x1_s2  <= x1_s1;

			d_s3   <= dp_s2[adrc_pkg::FRAC_BITS +: adrc_pkg::D_W];
			y_s3   <= $signed({{2{x1_s2[31]}}, x1_s2}) + $signed({a0_s2[32], a0_s2});
			a0_s3  <= a0_s2;

			s_s4       <= adrc_pkg::S_W'(d_s3) + adrc_pkg::S_W'({y_mag, 3'b000});
			side_s4.a0 <= a0_s3;
			side_s4.y  <= y_s3;
			side_s4.d  <= d_s3;
			side_s4.k  <= adrc_pkg::fsg2(adrc_pkg::MAG_W'(y_mag), d_s3);

			// The radicand product is split in two partial products of moderate width.
			pl_s5   <= 52'(side_s4.d) * 52'(s_s4[18:0]);
			ph_s5   <= 51'(side_s4.d) * 51'(s_s4[36:19]);
			side_s5 <= side_s4;

			rad_s6  <= adrc_pkg::RAD_W'(pl_s5) + {ph_s5, 19'b0};
			side_s6 <= side_s5;
		end
	end

	assign out_valid = v_s6;
	assign rad       = rad_s6;
	assign side      = side_s6;

endmodule

// ===== hw/rtl/adrc_sqrt.sv =====
// Pipelined floor square root, one root bit per stage, with sideband carried along.
// Depends on adrc_pkg.
module adrc_sqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               in_valid,
	input  logic [adrc_pkg::RAD_W-1:0]         rad,
	input  adrc_pkg::root_side_t               in_side,
	output logic                               out_valid,
	output logic [adrc_pkg::ROOT_W-1:0]        root,
	output adrc_pkg::root_side_t               out_side
);

	localparam int NS = adrc_pkg::ROOT_W;

	logic                              v_s    [NS];
	logic [adrc_pkg::RAD_W-1:0]        rad_s  [NS];
	logic [adrc_pkg::REM_W-1:0]        rem_s  [NS];
	logic [adrc_pkg::ROOT_W-1:0]       root_s [NS];
	adrc_pkg::root_side_t              side_s [NS];

	for (genvar i = 0; i < NS; i++) begin : g_stage
		logic                          v_in;
		logic [adrc_pkg::RAD_W-1:0]    rad_in;
		logic [adrc_pkg::REM_W-1:0]    rem_in;
		logic [adrc_pkg::ROOT_W-1:0]   root_in;
		adrc_pkg::root_side_t          side_in;
		logic [adrc_pkg::REM_W+1:0]    cur;
		logic [adrc_pkg::REM_W+1:0]    trial;
		logic [adrc_pkg::REM_W+1:0]    diff;
		logic                          take;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign rad_in  = rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = v_s[i-1];
			assign rad_in  = rad_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign side_in = side_s[i-1];
		end

		// Restoring step: bring down two radicand bits, try 4*root + 1.
		assign cur   = {rem_in, rad_in[adrc_pkg::RAD_W-1 -: 2]};
		assign trial = (adrc_pkg::REM_W+2)'({root_in, 2'b01});
		assign take  = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i] <= 1'b0;
			else if (adv)
				v_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_s[i]  <= {rad_in[adrc_pkg::RAD_W-3:0], 2'b00};
				rem_s[i]  <= take ? diff[adrc_pkg::REM_W-1:0] : cur[adrc_pkg::REM_W-1:0];
				root_s[i] <= {root_in[adrc_pkg::ROOT_W-2:0], take};
				side_s[i] <= side_in;
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign root      = root_s[NS-1];
	assign out_side  = side_s[NS-1];

endmodule

// ===== hw/rtl/adrc_mid.sv =====
// Middle stages: a2, the blended a, its window, and the dividend r*|a|.
// Depends on adrc_pkg.
module adrc_mid (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic [adrc_pkg::ROOT_W-1:0]   root,
	input  adrc_pkg::root_side_t          in_side,
	input  logic [adrc_pkg::R_W-1:0]      r,
	output logic                          out_valid,
	output logic [adrc_pkg::N_W-1:0]      num,
	output logic [adrc_pkg::D_W-1:0]      d,
	output adrc_pkg::quot_side_t          out_side
);

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [35:0]              a2_s1;
	logic signed [34:0]              sum0_s1;
	adrc_pkg::win_t                  k_s1, k_s2, k_s3, k_s4;
	logic [adrc_pkg::D_W-1:0]        d_s1, d_s2, d_s3, d_s4;

	logic signed [adrc_pkg::A_W-1:0] a_s2;

	logic [48:0]                     pl_s3, ph_s3;
	adrc_pkg::quot_side_t            side_s3, side_s4;

	logic [adrc_pkg::N_W-1:0]        num_s4;

	logic [adrc_pkg::ROOT_W-1:0]     excess;
	logic signed [35:0]              half_ex;
	logic signed [35:0]              a0_x;
	logic signed [35:0]              a2_nx;
	logic signed [adrc_pkg::A_W-1:0] blend;
	logic signed [adrc_pkg::A_W-1:0] blend_rnd;
	logic signed [adrc_pkg::A_W-1:0] a_nx;
	logic signed [adrc_pkg::A_W-1:0] a_neg;
	logic [adrc_pkg::MAG_W-1:0]      a_mag;

	// The root never falls below d, so the excess is not negative.
	assign excess  = root - adrc_pkg::ROOT_W'(in_side.d);
	assign half_ex = $signed({2'b00, excess[adrc_pkg::ROOT_W-1:1]});
	assign a0_x    = 36'(in_side.a0);

	always_comb begin
		if (in_side.y == '0)
			a2_nx = a0_x;
		else if (in_side.y < 0)
			a2_nx = a0_x - half_ex;
		else
			a2_nx = a0_x + half_ex;
	end

	// On the window edge a is the mean of both terms, truncated toward zero.
	assign blend     = adrc_pkg::A_W'(sum0_s1) + adrc_pkg::A_W'(a2_s1);
	assign blend_rnd = blend + $signed({{(adrc_pkg::A_W-1){1'b0}}, blend[adrc_pkg::A_W-1]});

	always_comb begin
		case (k_s1)
			adrc_pkg::WIN_IN:   a_nx = adrc_pkg::A_W'(sum0_s1);
			adrc_pkg::WIN_EDGE: a_nx = blend_rnd >>> 1;
			default:            a_nx = adrc_pkg::A_W'(a2_s1);
		endcase
	end

	assign a_neg = -a_s2;
	assign a_mag = a_s2[adrc_pkg::A_W-1] ? a_neg[adrc_pkg::MAG_W-1:0]
		: a_s2[adrc_pkg::MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a2_s1   <= a2_nx;
			sum0_s1 <= 35'(in_side.a0) + 35'(in_side.y);
			k_s1    <= in_side.k;
			d_s1    <= in_side.d;

			a_s2    <= a_nx;
			k_s2    <= k_s1;
			d_s2    <= d_s1;

			pl_s3         <= 49'(r) * 49'(a_mag[17:0]);
			ph_s3         <= 49'(r) * 49'(a_mag[35:18]);
			side_s3.k     <= k_s2;
			side_s3.g     <= adrc_pkg::fsg2(a_mag, d_s2);
			side_s3.aneg  <= a_s2[adrc_pkg::A_W-1];
			side_s3.azero <= (a_s2 == '0);
			k_s3          <= k_s2;
			d_s3          <= d_s2;

			num_s4  <= adrc_pkg::N_W'(pl_s3) + {ph_s3, 18'b0};
			side_s4 <= side_s3;
			k_s4    <= k_s3;
			d_s4    <= d_s3;
		end
	end

	assign out_valid = v_s4;
	assign num       = num_s4;
	assign d         = d_s4;
	assign out_side  = side_s4;

	// k is also kept in the sideband; this copy only follows the stages.
	logic unused_k;
	assign unused_k = ^k_s4;

endmodule

// ===== hw/rtl/adrc_div.sv =====
// Pipelined restoring divider for r*|a| / d, one quotient bit per stage, with an overflow check.
// Depends on adrc_pkg.
module adrc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic [adrc_pkg::N_W-1:0]      num,
	input  logic [adrc_pkg::D_W-1:0]      d,
	input  adrc_pkg::quot_side_t          in_side,
	output logic                          out_valid,
	output logic [adrc_pkg::Q_W-1:0]      quot,
	output logic                          over,
	output adrc_pkg::quot_side_t          out_side
);

	localparam int NS = adrc_pkg::Q_W;

	logic                          v_s0;
	logic                          over_s0;
	logic [adrc_pkg::D_W-1:0]      rem_s0;
	logic [adrc_pkg::Q_W-1:0]      low_s0;
	logic [adrc_pkg::D_W-1:0]      d_s0;
	adrc_pkg::quot_side_t          side_s0;

	logic                          v_s    [NS];
	logic                          over_s [NS];
	logic [adrc_pkg::D_W-1:0]      rem_s  [NS];
	logic [adrc_pkg::Q_W-1:0]      low_s  [NS];
	logic [adrc_pkg::Q_W-1:0]      q_s    [NS];
	logic [adrc_pkg::D_W-1:0]      d_s    [NS];
	adrc_pkg::quot_side_t          side_s [NS];

	// A quotient of 2^41 or more is caught here; the steps then only deliver the rest.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s0 <= 1'b0;
		else if (adv)
			v_s0 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			over_s0 <= {7'b0, num} >= {d, {adrc_pkg::Q_W{1'b0}}};
			rem_s0  <= adrc_pkg::D_W'(num[adrc_pkg::N_W-1:adrc_pkg::Q_W]);
			low_s0  <= num[adrc_pkg::Q_W-1:0];
			d_s0    <= d;
			side_s0 <= in_side;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_step
		logic                          v_in, over_in;
		logic [adrc_pkg::D_W-1:0]      rem_in, d_in;
		logic [adrc_pkg::Q_W-1:0]      low_in, q_in;
		adrc_pkg::quot_side_t          side_in;
		logic [adrc_pkg::D_W:0]        cur;
		logic [adrc_pkg::D_W:0]        diff;
		logic                          take;

		if (i == 0) begin : g_first
			assign v_in    = v_s0;
			assign over_in = over_s0;
			assign rem_in  = rem_s0;
			assign low_in  = low_s0;
			assign q_in    = '0;
			assign d_in    = d_s0;
			assign side_in = side_s0;
		end else begin : g_next
			assign v_in    = v_s[i-1];
			assign over_in = over_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign low_in  = low_s[i-1];
			assign q_in    = q_s[i-1];
			assign d_in    = d_s[i-1];
			assign side_in = side_s[i-1];
		end

		assign cur  = {rem_in, low_in[adrc_pkg::Q_W-1]};
		assign take = cur >= {1'b0, d_in};
		assign diff = cur - {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i] <= 1'b0;
			else if (adv)
				v_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				over_s[i] <= over_in;
				rem_s[i]  <= take ? diff[adrc_pkg::D_W-1:0] : cur[adrc_pkg::D_W-1:0];
				low_s[i]  <= {low_in[adrc_pkg::Q_W-2:0], 1'b0};
				q_s[i]    <= {q_in[adrc_pkg::Q_W-2:0], take};
				d_s[i]    <= d_in;
				side_s[i] <= side_in;
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign quot      = q_s[NS-1];
	assign over      = over_s[NS-1];
	assign out_side  = side_s[NS-1];

endmodule

// ===== hw/rtl/adrc_fastest_control_function.sv =====
// Han's time-optimal synthesis function fhan(x1, x2, r, h), signed Q16.16 in and out.
// Path of an input: front, root, middle and divider stages, then the output register.
// Throughput: one transaction per cycle; the root and divider pipelines retire one bit a stage.
// The whole pipeline holds while a finished result waits and m_tready is low.
// Reset (arst_n low, asynchronous) empties the pipeline and loads r = 30000, h = 1311/65536.
module adrc_fastest_control_function (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // pos_err [31:0], rate [63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // accel [31:0]
	output logic [0:0]  m_tuser,   // saturated [0]
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [30:0] cfg_data
);

	logic [adrc_pkg::R_W-1:0]     gain_r_q;
	logic [adrc_pkg::H_W-1:0]     step_h_q;

	logic                         adv;
	logic                         out_valid_q;
	logic [31:0]                  accel_q;
	logic                         sat_q;

	logic                         fr_valid;
	logic [adrc_pkg::RAD_W-1:0]   fr_rad;
	adrc_pkg::root_side_t         fr_side;

	logic                         sq_valid;
	logic [adrc_pkg::ROOT_W-1:0]  sq_root;
	adrc_pkg::root_side_t         sq_side;

	logic                         md_valid;
	logic [adrc_pkg::N_W-1:0]     md_num;
	logic [adrc_pkg::D_W-1:0]     md_d;
	adrc_pkg::quot_side_t         md_side;

	logic                         dv_valid;
	logic [adrc_pkg::Q_W-1:0]     dv_quot;
	logic                         dv_over;
	adrc_pkg::quot_side_t         dv_side;

	logic [adrc_pkg::Q_W-1:0]     q_cap;
	logic [adrc_pkg::TOT_W-1:0]   t1, t2, total;
	logic [31:0]                  accel_nx;
	logic                         sat_nx;

	assign adv      = m_tready | ~out_valid_q;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_r_q <= adrc_pkg::GAIN_R_RST;
			step_h_q <= adrc_pkg::STEP_H_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				adrc_pkg::REG_GAIN_R: gain_r_q <= cfg_data[adrc_pkg::R_W-1:0];
				adrc_pkg::REG_STEP_H: step_h_q <= cfg_data[adrc_pkg::H_W-1:0];
				default: ;
			endcase
		end
	end

	adrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.x1        (s_tdata[31:0]),
		.x2        (s_tdata[63:32]),
		.r         (gain_r_q),
		.h         (step_h_q),
		.out_valid (fr_valid),
		.rad       (fr_rad),
		.side      (fr_side)
	);

	adrc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (fr_valid),
		.rad       (fr_rad),
		.in_side   (fr_side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	adrc_mid u_mid (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (sq_valid),
		.root      (sq_root),
		.in_side   (sq_side),
		.r         (gain_r_q),
		.out_valid (md_valid),
		.num       (md_num),
		.d         (md_d),
		.out_side  (md_side)
	);

	adrc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (md_valid),
		.num       (md_num),
		.d         (md_d),
		.in_side   (md_side),
		.out_valid (dv_valid),
		.quot      (dv_quot),
		.over      (dv_over),
		.out_side  (dv_side)
	);

	assign q_cap = (dv_over || dv_quot > adrc_pkg::QUOT_CAP) ? adrc_pkg::QUOT_CAP : dv_quot;

	always_comb begin
		case (dv_side.k)
			adrc_pkg::WIN_IN:   t1 = adrc_pkg::TOT_W'(q_cap);
			adrc_pkg::WIN_EDGE: t1 = adrc_pkg::TOT_W'(q_cap >> 1);
			default:            t1 = '0;
		endcase
		case (dv_side.g)
			adrc_pkg::WIN_IN:   t2 = '0;
			adrc_pkg::WIN_EDGE: t2 = adrc_pkg::TOT_W'(gain_r_q >> 1);
			default:            t2 = adrc_pkg::TOT_W'(gain_r_q);
		endcase
	end

	assign total = t1 + t2;

	// The result takes the opposite sign of a and is clipped to 32 bits.
	always_comb begin
		accel_nx = '0;
		sat_nx   = 1'b0;
		if (dv_side.azero) begin
			accel_nx = '0;
		end else if (!dv_side.aneg) begin
			if (total > 42'h0_8000_0000) begin
				accel_nx = 32'h8000_0000;
				sat_nx   = 1'b1;
			end else begin
				accel_nx = -total[31:0];
			end
		end else begin
			if (total > 42'h0_7FFF_FFFF) begin
				accel_nx = 32'h7FFF_FFFF;
				sat_nx   = 1'b1;
			end else begin
				accel_nx = total[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			accel_q <= accel_nx;
			sat_q   <= sat_nx;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = accel_q;
	assign m_tuser[0] = sat_q;

endmodule

// ===== hw/rtl/adrc_checker.sv =====
// Port-level checks of the fhan block, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module adrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser
);

	`ASSERT_ALWAYS(a_empty_in_reset, !arst_n |-> !m_tvalid, "result shown during reset")

	`ASSERT_CLK(a_hold_out, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	`ASSERT_CLK(a_ready_rule, s_tready == (m_tready || !m_tvalid), "input ready does not follow output space")

	`ASSERT_CLK(a_sat_value, m_tvalid && m_tuser[0] |-> m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000, "saturation flag without a clipped value")

endmodule

bind adrc_fastest_control_function adrc_checker u_adrc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
